// File: sv/mie_pkg.sv
package mie_pkg;

  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DATA_WORDS);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] START_PC = 32'h0040_0000;
  localparam logic [31:0] EXIT_CODE = 32'd10;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDI_WRAP = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTI_UNS = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] F_SLL     = 6'h00;
  localparam logic [5:0] F_SRL     = 6'h02;
  localparam logic [5:0] F_SRA     = 6'h03;
  localparam logic [5:0] F_SLLV    = 6'h04;
  localparam logic [5:0] F_SRLV    = 6'h06;
  localparam logic [5:0] F_SRAV    = 6'h07;
  localparam logic [5:0] F_JR      = 6'h08;
  localparam logic [5:0] F_JALR    = 6'h09;
  localparam logic [5:0] F_SYSCALL = 6'h0C;
  localparam logic [5:0] F_MFHI    = 6'h10;
  localparam logic [5:0] F_MTHI    = 6'h11;
  localparam logic [5:0] F_MFLO    = 6'h12;
  localparam logic [5:0] F_MTLO    = 6'h13;
  localparam logic [5:0] F_MULT    = 6'h18;
  localparam logic [5:0] F_MULTU   = 6'h19;
  localparam logic [5:0] F_DIV     = 6'h1A;
  localparam logic [5:0] F_DIVU    = 6'h1B;
  localparam logic [5:0] F_ADD     = 6'h20;
  localparam logic [5:0] F_ADDU    = 6'h21;
  localparam logic [5:0] F_SUB     = 6'h22;
  localparam logic [5:0] F_SUBU    = 6'h23;
  localparam logic [5:0] F_AND     = 6'h24;
  localparam logic [5:0] F_OR      = 6'h25;
  localparam logic [5:0] F_XOR     = 6'h26;
  localparam logic [5:0] F_NOR     = 6'h27;
  localparam logic [5:0] F_SLT     = 6'h2A;
  localparam logic [5:0] F_SLTU    = 6'h2B;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0] LINK_REG = 5'd31;
  localparam logic [4:0] EXIT_REG = 5'd2;

  typedef struct packed {
    logic [31:0] instr;
    logic        is_mul;
    logic        mul_signed;
    logic        is_div;
    logic        div_signed;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t item;
  } queue_t;

endpackage

// File: sv/mie_chan_if.sv
interface mie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface mie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] hi_now;
  logic [31:0] lo_now;
  logic        store_done;
  logic        halted;
  modport source (output valid, output next_pc, output reg_written, output dest_index,
                  output dest_value, output hi_now, output lo_now, output store_done,
                  output halted, input ready);
  modport sink   (input valid, input next_pc, input reg_written, input dest_index,
                  input dest_value, input hi_now, input lo_now, input store_done,
                  input halted, output ready);
endinterface

interface mie_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mie_ram.sv
module mie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mie_div.sv
module mie_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sgn,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  import mie_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem_r, quo_r[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      if (divisor == 32'd0) begin
        // divide by zero: all-ones quotient, dividend as remainder
        quo_nxt   = '1;
        rem_nxt   = dividend;
        neg_q_nxt = 1'b0;
        neg_r_nxt = 1'b0;
      end else begin
        quo_nxt   = (sgn && dividend[31]) ? 32'd0 - dividend : dividend;
        dvs_nxt   = (sgn && divisor[31]) ? 32'd0 - divisor : divisor;
        rem_nxt   = '0;
        neg_q_nxt = sgn && (dividend[31] != divisor[31]);
        neg_r_nxt = sgn && dividend[31];
        cnt_nxt   = 6'd32;
        busy_nxt  = 1'b1;
      end
    end else if (busy_r) begin
      // one restoring step per cycle
      if (!rem_sub[32]) begin
        rem_nxt = rem_sub[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = neg_q_r ? 32'd0 - quo_r : quo_r;
  assign remainder = neg_r_r ? 32'd0 - rem_r : rem_r;

endmodule

// File: sv/mie_front.sv
module mie_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hold,
  mie_in_if.sink         in_bus,
  output mie_pkg::queue_t q_head,
  input  logic           q_pop
);
  import mie_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  dec_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push;
  dec_t          dec;
  logic [5:0]    op;
  logic [5:0]    fn;

  assign in_bus.ready = (cnt_r != QUEUE_DEPTH[PW:0]) && !hold;
  assign push = in_bus.valid && in_bus.ready;

  // classify: flag the long-latency arithmetic for the back end
  assign op = in_bus.instruction[31:26];
  assign fn = in_bus.instruction[5:0];
  always_comb begin
    dec.instr      = in_bus.instruction;
    dec.is_mul     = (op == OP_SPECIAL) && (fn == F_MULT || fn == F_MULTU);
    dec.mul_signed = (fn == F_MULT);
    dec.is_div     = (op == OP_SPECIAL) && (fn == F_DIV || fn == F_DIVU);
    dec.div_signed = (fn == F_DIV);
  end

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = slot_r[rptr_r];

endmodule

// File: sv/mie_back.sv
module mie_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mie_pkg::queue_t q_head,
  output logic            q_pop,
  output logic            hold,
  mie_out_if.source       out_bus
);
  import mie_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;

  logic [2:0]  state_r, state_nxt;
  dec_t        cur_r;
  logic [31:0] a_r, b_r, mem_r;
  logic [63:0] prod_r;
  logic [31:0] pc_r, hi_r, lo_r, r2_r;
  logic        halt_r;
  logic [31:0] rf_vld_r;
  logic        clr_r;
  logic [DMEM_AW-1:0] clr_cnt_r;

  logic        out_valid_r;
  logic [31:0] o_npc_r, o_val_r, o_hi_r, o_lo_r;
  logic [4:0]  o_idx_r;
  logic        o_wr_r, o_st_r, o_halt_r;

  // register file: two read copies, written together
  logic [31:0] rf_rdata_a, rf_rdata_b;
  logic [4:0]  rf_raddr_a, rf_raddr_b;
  logic        rf_we;
  logic [31:0] rs_val, rt_val;

  logic        dm_we;
  logic [DMEM_AW-1:0] dm_waddr, dm_raddr;
  logic [31:0] dm_wdata, dm_rdata;

  logic        div_busy;
  logic [31:0] div_q, div_r;
  logic        div_start;
  logic signed [65:0] prod_full;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, btarget, jtarget, pc4, pc8, addr_rd, addr_wb;
  logic        commit;

  logic        wr, st, halt_n;
  logic [4:0]  wd;
  logic [31:0] wv, npc, hi_n, lo_n, st_data;

  assign op  = cur_r.instr[31:26];
  assign rs  = cur_r.instr[25:21];
  assign rt  = cur_r.instr[20:16];
  assign rd  = cur_r.instr[15:11];
  assign sh  = cur_r.instr[10:6];
  assign fn  = cur_r.instr[5:0];
  assign imm = cur_r.instr[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc_r + 32'd4;
  assign pc8     = pc_r + 32'd8;
  assign btarget = pc_r + {simm[29:0], 2'b00};
  assign jtarget = {pc_r[31:28], cur_r.instr[25:0], 2'b00};

  mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(wd), .wdata(wv),
    .raddr(rf_raddr_a), .rdata(rf_rdata_a)
  );
  mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(wd), .wdata(wv),
    .raddr(rf_raddr_b), .rdata(rf_rdata_b)
  );
  mie_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );
  mie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .sgn(cur_r.div_signed),
    .dividend(a_r), .divisor(b_r), .busy(div_busy),
    .quotient(div_q), .remainder(div_r)
  );

  // reads are issued while the head item is popped
  assign rf_raddr_a = q_head.item.instr[25:21];
  assign rf_raddr_b = q_head.item.instr[20:16];
  assign rs_val = rf_vld_r[rs] ? rf_rdata_a : 32'd0;
  assign rt_val = rf_vld_r[rt] ? rf_rdata_b : 32'd0;

  assign addr_rd  = rs_val + simm;
  assign addr_wb  = a_r + simm;
  assign dm_raddr = addr_rd[DMEM_AW+1:2];

  assign hold   = clr_r;
  assign q_pop  = (state_r == S_IDLE) && q_head.valid && !clr_r;
  assign div_start = (state_r == S_EXEC) && cur_r.is_div && !halt_r;
  assign commit = (state_r == S_WB) && !(cur_r.is_div && (div_busy || div_start))
                  && (!out_valid_r || out_bus.ready);

  assign prod_full = $signed({cur_r.mul_signed & a_r[31], a_r})
                   * $signed({cur_r.mul_signed & b_r[31], b_r});

  // execute
  always_comb begin
    wr      = 1'b0;
    wd      = '0;
    wv      = '0;
    npc     = pc4;
    st      = 1'b0;
    st_data = b_r;
    hi_n    = hi_r;
    lo_n    = lo_r;
    halt_n  = halt_r;
    if (halt_r) begin
      npc = pc_r;
    end else if (op == OP_SPECIAL) begin
      wr = 1'b1;
      wd = rd;
      unique case (fn) inside
        F_AND:          wv = a_r & b_r;
        F_OR:           wv = a_r | b_r;
        F_XOR:          wv = a_r ^ b_r;
        F_NOR:          wv = ~(a_r | b_r);
        F_SLL:          wv = b_r << sh;
        F_SRL:          wv = b_r >> sh;
        F_SRA:          wv = 32'($signed(b_r) >>> sh);
        F_SLLV:         wv = b_r << a_r[4:0];
        F_SRLV:         wv = b_r >> a_r[4:0];
        F_SRAV:         wv = 32'($signed(b_r) >>> a_r[4:0]);
        F_MFHI:         wv = hi_r;
        F_MFLO:         wv = lo_r;
        F_ADD, F_ADDU:  wv = a_r + b_r;
        F_SUB, F_SUBU:  wv = a_r - b_r;
        F_SLT:          wv = {31'd0, $signed(a_r) < $signed(b_r)};
        F_SLTU:         wv = {31'd0, a_r < b_r};
        F_JALR: begin
          wv  = pc8;
          npc = a_r;
        end
        default: begin
          wr = 1'b0;
          unique case (fn) inside
            F_MTHI:          hi_n = a_r;
            F_MTLO:          lo_n = a_r;
            F_JR:            npc = a_r;
            F_MULT, F_MULTU: {hi_n, lo_n} = prod_r;
            F_DIV, F_DIVU: begin
              lo_n = div_q;
              hi_n = div_r;
            end
            F_SYSCALL:       halt_n = (r2_r == EXIT_CODE);
            default: ;
          endcase
        end
      endcase
    end else begin
      wr = 1'b1;
      wd = rt;
      unique case (op) inside
        OP_ANDI:            wv = a_r & {16'd0, imm};
        OP_ORI:             wv = a_r | {16'd0, imm};
        OP_XORI:            wv = a_r ^ {16'd0, imm};
        OP_LUI:             wv = {imm, 16'd0};
        OP_ADDI, OP_ADDI_WRAP: wv = a_r + simm;
        OP_SLTI:            wv = {31'd0, $signed(a_r) < $signed(simm)};
        OP_SLTI_UNS:        wv = {31'd0, a_r < simm};
        OP_LB:              wv = {{24{mem_r[7]}}, mem_r[7:0]};
        OP_LBU:             wv = {24'd0, mem_r[7:0]};
        OP_LH:              wv = {{16{mem_r[15]}}, mem_r[15:0]};
        OP_LHU:             wv = {16'd0, mem_r[15:0]};
        OP_LW:              wv = mem_r;
        OP_JAL: begin
          wd  = LINK_REG;
          wv  = pc8;
          npc = jtarget;
        end
        default: begin
          wr = 1'b0;
          unique case (op) inside
            OP_BEQ:  if (a_r == b_r) npc = btarget;
            OP_BNE:  if (a_r != b_r) npc = btarget;
            OP_BGTZ: if (!a_r[31] && a_r != 32'd0) npc = btarget;
            OP_BLEZ: if (a_r[31] || a_r == 32'd0) npc = btarget;
            OP_REGIMM: begin
              if (rt == RI_BGEZ && !a_r[31]) begin
                npc = btarget;
              end else if (rt == RI_BLTZ && a_r[31]) begin
                npc = btarget;
              end else if ((rt == RI_BLTZAL && a_r[31]) || (rt == RI_BGEZAL && !a_r[31])) begin
                npc = btarget;
                wr  = 1'b1;
                wd  = LINK_REG;
                wv  = pc8;
              end
            end
            OP_J:    npc = jtarget;
            OP_SB: begin
              st      = 1'b1;
              st_data = {24'd0, b_r[7:0]};
            end
            OP_SH: begin
              st      = 1'b1;
              st_data = {16'd0, b_r[15:0]};
            end
            OP_SW:   st = 1'b1;
            default: ;
          endcase
        end
      endcase
    end
    // drop writes aimed at register zero
    if (wr && wd == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      wd = '0;
      wv = '0;
    end
  end

  assign rf_we    = commit && wr;
  assign dm_we    = clr_r || (commit && st);
  assign dm_waddr = clr_r ? clr_cnt_r : addr_wb[DMEM_AW+1:2];
  assign dm_wdata = clr_r ? 32'd0 : st_data;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_pop) state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_WB;
      S_WB:    if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= START_PC;
      hi_r        <= '0;
      lo_r        <= '0;
      r2_r        <= '0;
      halt_r      <= 1'b0;
      rf_vld_r    <= '0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == DMEM_AW'(DATA_WORDS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        pc_r        <= npc;
        hi_r        <= hi_n;
        lo_r        <= lo_n;
        halt_r      <= halt_n;
        out_valid_r <= 1'b1;
        if (wr) begin
          rf_vld_r[wd] <= 1'b1;
          if (wd == EXIT_REG) begin
            r2_r <= wv;
          end
        end
      end
    end
    if (q_pop) begin
      cur_r <= q_head.item;
    end
    if (state_r == S_READ) begin
      a_r <= rs_val;
      b_r <= rt_val;
    end
    if (state_r == S_EXEC) begin
      mem_r  <= dm_rdata;
    end
    if ((state_r == S_EXEC) && cur_r.is_mul) begin
      prod_r <= prod_full[63:0];
    end
    if (commit) begin
      o_npc_r  <= npc;
      o_wr_r   <= wr;
      o_idx_r  <= wd;
      o_val_r  <= wv;
      o_hi_r   <= hi_n;
      o_lo_r   <= lo_n;
      o_st_r   <= st;
      o_halt_r <= halt_n;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.next_pc     = o_npc_r;
  assign out_bus.reg_written = o_wr_r;
  assign out_bus.dest_index  = o_idx_r;
  assign out_bus.dest_value  = o_val_r;
  assign out_bus.hi_now      = o_hi_r;
  assign out_bus.lo_now      = o_lo_r;
  assign out_bus.store_done  = o_st_r;
  assign out_bus.halted      = o_halt_r;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !q_pop) else $error("item popped during memory clear");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag dropped");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cur_r.is_div) |-> !div_busy) else $error("divide committed early");
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (wd != 5'd0)) else $error("write to register zero");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> $stable(o_npc_r)) else $error("result overwritten");
`endif

endmodule

// File: sv/mips_integer_instruction_executor.sv
// Flow: pop, register read, execute with data memory read, writeback; the result beat is
//   registered at writeback, which waits while an earlier result is not taken; div/divu by a
//   nonzero divisor also wait for the radix-2 divider before writeback.
// Instructions run one at a time: the next is popped only after the last one writes back.
// Reset (synchronous, rst_n low): PC to 0x00400000, registers, HI, LO, halt cleared;
//   then a pass zeroes all 1024 data memory words, during which no instruction beat is taken.
module mips_integer_instruction_executor (
  input  logic   clk,
  input  logic   rst_n,
  mie_in_if.sink     in_bus,
  mie_out_if.source  out_bus,
  mie_cfg_if.sink    cfg_bus
);
  import mie_pkg::*;

  queue_t q_head;
  logic   q_pop;
  logic   hold;

  // The start address is restored by reset together with the PC, so a write
  // has no effect on any later instruction; accept every beat.
  assign cfg_bus.ready = 1'b1;

  // Front end: take instruction beats, classify, buffer in a short queue.
  mie_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .hold   (hold),
    .in_bus (in_bus),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back end: multicycle execute, register file, data memory, HI/LO, divider,
  // and the result register that decouples the output beat.
  mie_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .hold    (hold),
    .out_bus (out_bus)
  );

endmodule
